/* hw/rtl/rmba_pkg.sv */
// Shared types and constants for the ring message buffer allocator.
`default_nettype none

package rmba_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam int POOL_BYTES_DEF = 16384;

	localparam int LEN_W    = 14;
	localparam int OFFSET_W = 14;
	localparam int COUNT_W  = 16;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_REQUEST = 2'd0,
		OP_GET     = 2'd1,
		OP_FREE    = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_SLOT  = 2'd1,
		ST_NO_SPACE = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/rmba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rmba_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/rmba_ctrl.sv */
// Controller state machine: input capture, execution and output handshake.
`default_nettype none

module rmba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output rmba_pkg::cmd_t     cmd
);

	import rmba_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	always_comb begin
		cmd.capture = in_valid && in_ready_q;
		cmd.commit  = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (cmd.capture) begin
						state_q    <= S_EXEC;
						in_ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (cmd.commit) begin
						state_q     <= S_IDLE;
						in_ready_q  <= 1'b1;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	a_capture_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_EXEC) && !in_ready_q)
		else $error("capture did not enter execution");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q && in_ready_q && (state_q == S_IDLE))
		else $error("commit did not present a result");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready_q |-> (state_q == S_IDLE))
		else $error("ready outside idle");

endmodule

`default_nettype wire

/* hw/rtl/rmba_dp.sv */
// Datapath: ring indices, free offset, slot table, counters and result.
`default_nettype none

module rmba_dp #(
	parameter int SLOT_COUNT = rmba_pkg::SLOT_COUNT_DEF,
	parameter int POOL_BYTES = rmba_pkg::POOL_BYTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire rmba_pkg::cmd_t                  cmd,
	input  wire logic [rmba_pkg::OP_W-1:0]       op_in,
	input  wire logic [rmba_pkg::LEN_W-1:0]      len_in,
	output logic      [rmba_pkg::STATUS_W-1:0]   res_status,
	output logic      [rmba_pkg::OFFSET_W-1:0]   res_offset,
	output logic      [rmba_pkg::COUNT_W-1:0]    res_grants,
	output logic      [rmba_pkg::COUNT_W-1:0]    res_reads
);

	import rmba_pkg::*;

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int OW = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;
	localparam int CW = ((OW > LEN_W) ? OW : LEN_W) + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
	localparam logic [CW-1:0] POOL_C   = CW'(POOL_BYTES);

	op_t               op_q;
	logic [LEN_W-1:0]  len_q;
	logic [IW-1:0]     head_q;
	logic [IW-1:0]     tail_q;
	logic [OW-1:0]     head_off_q;
	logic [COUNT_W-1:0] grant_q;
	logic [COUNT_W-1:0] read_q;
	status_t           status_q;
	logic [OFFSET_W-1:0] offset_q;

	logic [OW-1:0]     rd_data;
	logic [IW-1:0]     nxt_head;
	logic [IW-1:0]     nxt_tail;
	logic              empty;
	logic              full;
	logic [CW-1:0]     h_c;
	logic [CW-1:0]     t_c;
	logic [CW-1:0]     len_c;
	logic [CW-1:0]     gnt_off;
	logic              grant;
	logic              do_read;
	logic              do_free;
	status_t           st;
	logic [CW-1:0]     off;

	rmba_ram #(
		.WIDTH(OW),
		.DEPTH(SLOT_COUNT)
	) u_slots (
		.clk  (clk),
		.we   (cmd.commit && grant),
		.waddr(head_q),
		.wdata(OW'(gnt_off)),
		.re   (cmd.capture),
		.raddr(tail_q),
		.rdata(rd_data)
	);

	always_comb begin
		nxt_head = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
		nxt_tail = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
		empty    = (head_q == tail_q);
		full     = (nxt_head == tail_q);
		h_c      = CW'(head_off_q);
		t_c      = empty ? CW'(head_off_q) : CW'(rd_data);
		len_c    = CW'(len_q);
		gnt_off  = h_c;
		grant    = 1'b0;
		do_read  = 1'b0;
		do_free  = 1'b0;
		st       = ST_OK;
		off      = '0;
		unique case (op_q)
			OP_REQUEST: begin
				if (full) begin
					st = ST_NO_SLOT;
				end else begin
					if (h_c < t_c) begin
						grant = (t_c - h_c) > len_c;
					end else if ((POOL_C - h_c) > len_c) begin
						grant = 1'b1;
					end else if (t_c > len_c) begin
						grant   = 1'b1;
						gnt_off = '0;
					end
					if (grant) begin
						off = gnt_off;
					end else begin
						st = ST_NO_SPACE;
					end
				end
			end
			OP_GET: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					do_read = 1'b1;
					off     = t_c;
				end
			end
			OP_FREE: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					do_free = 1'b1;
					off     = t_c;
				end
			end
			OP_NOP: begin
				st = ST_OK;
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(op_in);
			len_q <= len_in;
		end
		if (cmd.commit) begin
			status_q <= st;
			offset_q <= off[OFFSET_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			head_off_q <= '0;
			grant_q    <= '0;
			read_q     <= '0;
		end else if (cmd.commit) begin
			if (grant) begin
				head_q     <= nxt_head;
				head_off_q <= OW'(gnt_off + len_c);
				grant_q    <= grant_q + 1'b1;
			end
			if (do_read) begin
				read_q <= read_q + 1'b1;
			end
			if (do_free) begin
				tail_q <= nxt_tail;
			end
		end
	end

	assign res_status = status_q;
	assign res_offset = offset_q;
	assign res_grants = grant_q;
	assign res_reads  = read_q;

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(grant_q) && $stable(read_q) && $stable(head_q)
			&& $stable(tail_q) && $stable(head_off_q))
		else $error("ring state moved without a commit");

	a_free_offset: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(head_off_q) < POOL_C)
		else $error("free offset beyond pool");

	a_free_tail: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (op_q == OP_FREE) && !empty |=> tail_q == $past(nxt_tail))
		else $error("free did not advance tail");

endmodule

`default_nettype wire

/* hw/rtl/ring_message_buffer_allocator.sv */
// Top level of the ring message buffer allocator.
//
// Input stream: s_tuser carries the operation (request, get, free, no-op),
// s_tdata the requested length. Output stream: one result transaction per
// input transaction, status on m_tuser, offset and both wrapping counters
// on m_tdata.
// Each transaction is handled in turn: it is captured and the oldest slot
// offset is read from the slot table, then the block decides, updates the
// ring and loads the result register. A new transaction is not taken until
// the current one has loaded its result.
// s_tready rises again as soon as a result is loaded, so the next
// transaction is captured while the previous result waits; if m_tready
// stays low the block holds in execution until the result register frees.
// Reset clears the ring indices, the free offset and both counters; the
// slot table needs no clearing, since only entries written by a grant are
// ever read.
`default_nettype none

module ring_message_buffer_allocator #(
	parameter int SLOT_COUNT = rmba_pkg::SLOT_COUNT_DEF,
	parameter int POOL_BYTES = rmba_pkg::POOL_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [13:0] length, [15:14] zero
	input  wire logic [1:0]  s_tuser,  // [1:0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata,  // [13:0] offset, [29:14] grant_count,
	                                   // [45:30] read_count, [47:46] zero
	output logic      [1:0]  m_tuser   // [1:0] status
);

	import rmba_pkg::*;

	cmd_t                 cmd;
	logic [STATUS_W-1:0]  res_status;
	logic [OFFSET_W-1:0]  res_offset;
	logic [COUNT_W-1:0]   res_grants;
	logic [COUNT_W-1:0]   res_reads;

	rmba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.cmd      (cmd)
	);

	rmba_dp #(
		.SLOT_COUNT(SLOT_COUNT),
		.POOL_BYTES(POOL_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op_in     (s_tuser),
		.len_in    (s_tdata[LEN_W-1:0]),
		.res_status(res_status),
		.res_offset(res_offset),
		.res_grants(res_grants),
		.res_reads (res_reads)
	);

	assign m_tdata = {2'b00, res_reads, res_grants, res_offset};
	assign m_tuser = res_status;

endmodule

`default_nettype wire

/* sim/ring_message_buffer_allocator_tb.sv */
// Testbench for the ring message buffer allocator: directed, ring-full and random tests.
`timescale 1ns / 100ps

module ring_message_buffer_allocator_tb;
	import rmba_pkg::*;

	localparam int SLOTS          = SLOT_COUNT_DEF;
	localparam int POOL           = POOL_BYTES_DEF;
	localparam int LEN_MAX        = (1 << LEN_W) - 1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1450;

	typedef enum {
		MIX_FILL,
		MIX_DRAIN,
		MIX_BULK,
		MIX_ANY
	} traffic_t;

	typedef struct {
		status_t             status;
		logic [OFFSET_W-1:0] offset;
		logic [COUNT_W-1:0]  grants;
		logic [COUNT_W-1:0]  reads;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	int ring_head;
	int ring_tail;
	logic [OFFSET_W-1:0] slot_base [SLOTS];
	logic [COUNT_W-1:0]  grant_total;
	logic [COUNT_W-1:0]  read_total;

	alloc_result_t expected_q [$];
	int  fail_count;
	int  quiet_cycles;
	int  stall_left;
	int  sent_items;
	bit  idle_on;
	bit  stall_on;

	ring_message_buffer_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int next_slot(int i);
		return (i == SLOTS - 1) ? 0 : i + 1;
	endfunction

	task automatic clear_allocator_model();
		ring_head   = 0;
		ring_tail   = 0;
		grant_total = '0;
		read_total  = '0;
		foreach (slot_base[i])
			slot_base[i] = '0;
	endtask

	function automatic alloc_result_t predict_alloc(input op_t op, input logic [LEN_W-1:0] len);
		alloc_result_t res;
		int  h;
		int  t;
		bit  grant;
		bit  empty;
		res.status = ST_OK;
		res.offset = '0;
		empty = (ring_head == ring_tail);
		case (op)
			OP_REQUEST: begin
				if (next_slot(ring_head) == ring_tail) begin
					res.status = ST_NO_SLOT;
				end else begin
					h = slot_base[ring_head];
					t = slot_base[ring_tail];
					grant = 1'b0;
					if (h < t) begin
						grant = (t - h) > len;
					end else if (POOL - h > len) begin
						grant = 1'b1;
					end else if (t > len) begin
						h = 0;
						slot_base[ring_head] = '0;
						grant = 1'b1;
					end
					if (grant) begin
						grant_total = grant_total + 1'b1;
						res.offset  = OFFSET_W'(h);
						ring_head   = next_slot(ring_head);
						slot_base[ring_head] = OFFSET_W'(h + len);
					end else begin
						res.status = ST_NO_SPACE;
					end
				end
			end
			OP_GET: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					read_total = read_total + 1'b1;
					res.offset = slot_base[ring_tail];
				end
			end
			OP_FREE: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					res.offset = slot_base[ring_tail];
					ring_tail  = next_slot(ring_tail);
				end
			end
			default: ;
		endcase
		res.grants = grant_total;
		res.reads  = read_total;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic op_t pick_op(traffic_t mode);
		int r;
		int req_w;
		int get_w;
		int free_w;
		r = $urandom_range(0, 99);
		case (mode)
			MIX_FILL:  begin req_w = 70; get_w = 80; free_w = 95; end
			MIX_DRAIN: begin req_w = 15; get_w = 30; free_w = 95; end
			MIX_BULK:  begin req_w = 55; get_w = 65; free_w = 95; end
			default:   begin req_w = 40; get_w = 60; free_w = 90; end
		endcase
		if (r < req_w)
			return OP_REQUEST;
		if (r < get_w)
			return OP_GET;
		if (r < free_w)
			return OP_FREE;
		return OP_NOP;
	endfunction

	function automatic logic [LEN_W-1:0] pick_len(traffic_t mode);
		int r;
		int h;
		int t;
		int room;
		r = $urandom_range(0, 99);
		h = slot_base[ring_head];
		t = slot_base[ring_tail];
		if (r < 20) begin
			if (h < t)
				room = t - h;
			else if ($urandom_range(0, 1))
				room = POOL - h;
			else
				room = t;
			room = room - int'($urandom_range(0, 1));
			if (room < 0)
				room = 0;
			if (room > LEN_MAX)
				room = LEN_MAX;
			return LEN_W'(room);
		end
		if (r < 30) begin
			case ($urandom_range(0, 3))
				0:       return '0;
				1:       return LEN_W'(1);
				2:       return LEN_W'(LEN_MAX - 1);
				default: return LEN_W'(LEN_MAX);
			endcase
		end
		case (mode)
			MIX_FILL, MIX_DRAIN: return LEN_W'($urandom_range(0, 255));
			MIX_BULK:            return LEN_W'($urandom_range(2048, LEN_MAX));
			default:             return LEN_W'($urandom_range(0, LEN_MAX));
		endcase
	endfunction

	task automatic report(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic send_op(input op_t op, input logic [LEN_W-1:0] len);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, len};
		do @(posedge clk); while (!s_tready);
		expected_q.push_back(predict_alloc(op, len));
		sent_items++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
	endtask

	task automatic check_result();
		alloc_result_t want;
		if (expected_q.size() == 0) begin
			report($sformatf("result with nothing expected: tuser %0d tdata %h", m_tuser, m_tdata));
			return;
		end
		want = expected_q.pop_front();
		if (m_tuser !== want.status)
			report($sformatf("status %0d, expected %0d", m_tuser, want.status));
		if (m_tdata[13:0] !== want.offset)
			report($sformatf("offset %0d, expected %0d", m_tdata[13:0], want.offset));
		if (m_tdata[29:14] !== want.grants)
			report($sformatf("grant_count %0d, expected %0d", m_tdata[29:14], want.grants));
		if (m_tdata[45:30] !== want.reads)
			report($sformatf("read_count %0d, expected %0d", m_tdata[45:30], want.reads));
		if (m_tdata[47:46] !== 2'b00)
			report($sformatf("padding bits %b, expected zero", m_tdata[47:46]));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result();
		if (!arst_n || !stall_on) begin
			m_tready   <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 30) begin
			m_tready   <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR at %0t: no transaction for %0d cycles", $time, quiet_cycles);
				$display("ring_message_buffer_allocator_tb failed");
				$finish;
			end
		end
	end

	task automatic test_directed();
		idle_on  = 1'b1;
		stall_on = 1'b1;
		send_op(OP_GET, '0);
		send_op(OP_FREE, '0);
		send_op(OP_NOP, LEN_W'(LEN_MAX));
		send_op(OP_REQUEST, '0);
		send_op(OP_REQUEST, LEN_W'(LEN_MAX));
		send_op(OP_REQUEST, '0);
		send_op(OP_REQUEST, LEN_W'(1));
		send_op(OP_GET, '0);
		send_op(OP_FREE, '0);
		send_op(OP_FREE, '0);
		send_op(OP_GET, '0);
		send_op(OP_FREE, '0);
		send_op(OP_REQUEST, LEN_W'(100));
		send_op(OP_REQUEST, LEN_W'(200));
		send_op(OP_FREE, '0);
		send_op(OP_REQUEST, LEN_W'(16000));
		send_op(OP_REQUEST, LEN_W'(83));
		send_op(OP_REQUEST, LEN_W'(50));
		send_op(OP_REQUEST, LEN_W'(49));
		send_op(OP_REQUEST, LEN_W'(1));
		send_op(OP_REQUEST, '0);
		send_op(OP_NOP, '0);
		send_op(OP_GET, LEN_W'(LEN_MAX));
	endtask

	task automatic test_ring_full();
		idle_on  = 1'b1;
		stall_on = 1'b1;
		repeat (SLOTS + 6)
			send_op(OP_REQUEST, '0);
		send_op(OP_GET, '0);
		send_op(OP_REQUEST, LEN_W'(LEN_MAX));
		repeat (SLOTS + 6)
			send_op(OP_FREE, '0);
		send_op(OP_GET, '0);
	endtask

	task automatic test_random_traffic();
		traffic_t mode;
		int       burst;
		int       start_count;
		bit       paused;
		start_count = sent_items;
		paused      = 1'b0;
		while (sent_items - start_count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0:       mode = MIX_FILL;
				1:       mode = MIX_DRAIN;
				2:       mode = MIX_BULK;
				default: mode = MIX_ANY;
			endcase
			idle_on  = ($urandom_range(0, 4) != 0);
			stall_on = ($urandom_range(0, 4) != 0);
			burst    = $urandom_range(8, 60);
			repeat (burst)
				send_op(pick_op(mode), pick_len(mode));
			if (!paused && sent_items - start_count >= RANDOM_ITEMS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = OP_NOP;
		m_tready     = 1'b0;
		fail_count   = 0;
		quiet_cycles = 0;
		stall_left   = 0;
		sent_items   = 0;
		idle_on      = 1'b1;
		stall_on     = 1'b1;
		clear_allocator_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_ring_full();
		test_random_traffic();

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("ring_message_buffer_allocator_tb passed");
		else
			$display("ring_message_buffer_allocator_tb failed");
		$finish;
	end

endmodule

/* ring_message_buffer_allocator.f */
hw/rtl/rmba_pkg.sv
hw/rtl/rmba_ram.sv
hw/rtl/rmba_ctrl.sv
hw/rtl/rmba_dp.sv
hw/rtl/ring_message_buffer_allocator.sv
sim/ring_message_buffer_allocator_tb.sv
